// ===== hdl/assert_macros.svh =====
// Assertion macros used by the resolver RTL.
// Depends on nothing; included by tbpr_ctrl, the module that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, masked while reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tbpr_pkg.sv =====
// Types and constants of the tile background pixel resolver.
// Depends on nothing; used by the sequencer and the top level.
package tbpr_pkg;

    localparam int VRAM_DEPTH = 8192;
    localparam int VRAM_AW    = 13;
    localparam int BYTE_W     = 8;

    localparam logic [VRAM_AW-1:0] VRAM_LAST          = 13'h1FFF;
    localparam logic [VRAM_AW-1:0] MAP0_OFFSET        = 13'h1800;
    localparam logic [VRAM_AW-1:0] MAP1_OFFSET        = 13'h1C00;
    localparam logic [VRAM_AW-1:0] SIGNED_TILE_OFFSET = 13'h1000;
    localparam logic [VRAM_AW-1:0] SIGNED_TILE_SPAN   = 13'h0800;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_PIXEL = 2'd2;

    localparam logic [1:0] CFG_MAP_SELECT = 2'd0;
    localparam logic [1:0] CFG_TILE_MODE  = 2'd1;
    localparam logic [1:0] CFG_VIEW_X     = 2'd2;
    localparam logic [1:0] CFG_VIEW_Y     = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [VRAM_AW-1:0] vram_addr;
        logic [BYTE_W-1:0]  wr_data;
        logic [7:0]         screen_x;
        logic [7:0]         screen_y;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rd_data;
        logic [1:0]        color;
    } out_word_t;

    typedef struct packed {
        logic       map_select;
        logic       tile_mode;
        logic [7:0] view_x;
        logic [7:0] view_y;
    } cfg_t;

    typedef struct packed {
        logic               we;
        logic [VRAM_AW-1:0] addr;
        logic [BYTE_W-1:0]  wdata;
    } ram_req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH_LO,
        ST_FETCH_HI,
        ST_RESOLVE,
        ST_HOLD
    } state_t;

endpackage

// ===== hdl/tbpr_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module tbpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/tbpr_ctrl.sv =====
// Sequencer of the resolver: memory clearing, word handling and the output register.
// Depends on tbpr_pkg and assert_macros.svh; drives the video memory port.
`include "assert_macros.svh"

module tbpr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  tbpr_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  tbpr_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output tbpr_pkg::out_word_t out_word,
    output tbpr_pkg::ram_req_t  ram_req,
    input  logic [7:0]          ram_rdata
);

    import tbpr_pkg::*;

    state_t             state_reg, state_next;
    logic [VRAM_AW-1:0] clr_reg, clr_next;
    logic [1:0]         func_reg, func_next;
    logic [2:0]         bx_reg, bx_next;
    logic [2:0]         by_reg, by_next;
    logic [VRAM_AW-1:0] row_reg, row_next;
    logic               lo_reg, lo_next;
    out_word_t          hold_reg, hold_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_word_reg, out_word_next;

    logic               ready;
    logic               accept;
    logic               slot_free;
    logic [7:0]         bx_in;
    logic [7:0]         by_in;
    logic [VRAM_AW-1:0] map_addr;
    logic [VRAM_AW-1:0] tile_addr;
    out_word_t          res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        bx_reg       <= bx_next;
        by_reg       <= by_next;
        row_reg      <= row_next;
        lo_reg       <= lo_next;
        hold_reg     <= hold_next;
        out_word_reg <= out_word_next;
    end

    assign slot_free = !out_valid_reg || !out_stall;
    assign bx_in     = in_word.screen_x + cfg.view_x;
    assign by_in     = in_word.screen_y + cfg.view_y;
    assign map_addr  = (cfg.map_select ? MAP1_OFFSET : MAP0_OFFSET)
                     | {3'b000, by_in[7:3], bx_in[7:3]};

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        func_next      = func_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        row_next       = row_reg;
        lo_next        = lo_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        ram_req        = '0;
        ready          = 1'b0;
        res            = '0;
        tile_addr      = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_req.we   = 1'b1;
                ram_req.addr = clr_reg;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == VRAM_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ready = 1'b1;
            end
            ST_FETCH_LO:
            begin
                if (cfg.tile_mode)
                begin
                    tile_addr = {1'b0, ram_rdata, 4'b0000};
                end
                else
                begin
                    tile_addr = SIGNED_TILE_OFFSET + {2'b00, ram_rdata[6:0], 4'b0000};
                    if (ram_rdata[7])
                    begin
                        tile_addr = tile_addr - SIGNED_TILE_SPAN;
                    end
                end
                row_next     = tile_addr + {9'd0, by_reg, 1'b0};
                ram_req.addr = row_next;
                state_next   = ST_FETCH_HI;
            end
            ST_FETCH_HI:
            begin
                lo_next      = ram_rdata[~bx_reg];
                ram_req.addr = {row_reg[VRAM_AW-1:1], 1'b1};
                state_next   = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                case (func_reg)
                    FUNC_READ:
                    begin
                        res.rd_data = ram_rdata;
                    end
                    FUNC_PIXEL:
                    begin
                        res.color = {ram_rdata[~bx_reg], lo_reg};
                    end
                    default:
                    begin
                        res = '0;
                    end
                endcase
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = res;
                    ready          = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    hold_next  = res;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = hold_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        accept = ready && in_valid;

        if (accept)
        begin
            func_next = in_word.func;
            bx_next   = bx_in[2:0];
            by_next   = by_in[2:0];
            case (in_word.func)
                FUNC_WRITE:
                begin
                    ram_req.we    = 1'b1;
                    ram_req.addr  = in_word.vram_addr;
                    ram_req.wdata = in_word.wr_data;
                    state_next    = ST_RESOLVE;
                end
                FUNC_READ:
                begin
                    ram_req.addr = in_word.vram_addr;
                    state_next   = ST_RESOLVE;
                end
                FUNC_PIXEL:
                begin
                    ram_req.addr = map_addr;
                    state_next   = ST_FETCH_LO;
                end
                default:
                begin
                    state_next = ST_RESOLVE;
                end
            endcase
        end
    end

    assign in_stall  = !ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `ASSERT_CLK(a_no_accept_in_clear, clk, (state_reg == ST_CLEAR) |-> in_stall, "word accepted during clearing")
    `ASSERT_CLK_RST(a_write_source, clk, rst_n, ram_req.we |-> ((state_reg == ST_CLEAR) || (accept && (in_word.func == FUNC_WRITE))), "stray memory write")
    `ASSERT_CLK_RST(a_pixel_fetch, clk, rst_n, (accept && (in_word.func == FUNC_PIXEL)) |=> (state_reg == ST_FETCH_LO), "pixel did not start its map fetch")
    `ASSERT_CLK_RST(a_hold_blocked, clk, rst_n, (state_reg == ST_HOLD) |-> out_valid_reg, "held result without a pending output word")

endmodule

// ===== hdl/tile_background_pixel_resolver.sv =====
// A read, write or unused word is resolved in ST_RESOLVE and registered as the output word;
// a pixel first reads the map, then the low and high tile row bytes on the single memory port.
// Reads and writes may follow every cycle unless the output stalls; pixels go one at a time.
// After reset the video memory is cleared one byte a cycle, during which
// no word is accepted; configuration writes are taken at any time and reset to their defaults.
// Top level: configuration registers, video memory and sequencer; depends on tbpr_pkg.
module tile_background_pixel_resolver (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tbpr_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output tbpr_pkg::out_word_t out_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    import tbpr_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    ram_req_t ram_req;
    logic [BYTE_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{map_select: 1'b0, tile_mode: 1'b1, view_x: 8'd0, view_y: 8'd0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAP_SELECT: cfg_next.map_select = cfg_data[0];
                CFG_TILE_MODE:  cfg_next.tile_mode  = cfg_data[0];
                CFG_VIEW_X:     cfg_next.view_x     = cfg_data;
                CFG_VIEW_Y:     cfg_next.view_y     = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    tbpr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (VRAM_DEPTH)
    ) u_vram (
        .clk   (clk),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    tbpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

endmodule
